FILE: rtl/apr_pkg.sv
package apr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int MAX_PAGES  = 64;
    localparam int AGE_BITS   = 9;

    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int CNT_W   = 16;
    localparam int NFR_W   = 5;
    localparam int NPG_W   = 7;

    // Register indexes on the configuration port.
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic REG_PAGES_IN_USE  = 1'b1;

    localparam logic [NFR_W-1:0] FRAMES_RESET = NFR_W'(MAX_FRAMES);
    localparam logic [NPG_W-1:0] PAGES_RESET  = NPG_W'(MAX_PAGES);

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last_ref;
    } ref_t;

    typedef struct packed {
        logic               fault;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [CNT_W-1:0]   fault_total;
        logic               bad_page;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic bad;
        logic hit;
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/apr_ctrl.sv
module apr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ref_valid,
    input  apr_pkg::stat_t stat,
    output apr_pkg::cmd_t  cmd,
    output logic          idle
);
    import apr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        idle           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (ref_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (stat.bad || stat.hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/apr_datapath.sv
module apr_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  apr_pkg::cmd_t              cmd,
    output apr_pkg::stat_t             stat,
    input  apr_pkg::ref_t              ref_data,
    input  logic [apr_pkg::NFR_W-1:0]  frames_in_use,
    input  logic [apr_pkg::NPG_W-1:0]  pages_in_use,
    output logic                       res_valid,
    input  logic                       res_stall,
    output apr_pkg::res_t              res_data
);
    import apr_pkg::*;

    // Latched item.
    logic [PAGE_W-1:0]  page_reg;
    logic               last_reg;

    // Frame side: owner has no reset, occupancy is cleared.
    logic [PAGE_W-1:0]  owner_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] occupied_reg;

    // Page side: location memory with a valid bit per page.
    logic [FRAME_W-1:0] loc_mem [MAX_PAGES];
    logic [FRAME_W-1:0] loc_rdata_reg;
    logic [MAX_PAGES-1:0] loc_valid_reg;

    logic [AGE_BITS-1:0] age_reg [MAX_PAGES];
    logic [CNT_W-1:0]    count_reg;

    // Victim search.
    logic [FRAME_W-1:0]  scan_reg;
    logic [FRAME_W-1:0]  victim_reg;
    logic [AGE_BITS-1:0] best_age_reg;
    logic [PAGE_W-1:0]   best_owner_reg;
    logic                have_best_reg;
    logic                found_empty_reg;

    logic                res_valid_reg;
    res_t                res_reg;

    logic [FRAME_W-1:0]  last_frame;
    logic [NPG_W-1:0]    npages;
    logic [PAGE_W-1:0]   scan_owner;
    logic [AGE_BITS-1:0] scan_age;
    logic                scan_better;
    logic                miss;
    logic                evict;
    logic [CNT_W-1:0]    count_next;
    res_t                res_next;

    // Effective register values after clamping to the legal range.
    always_comb
    begin
        if (frames_in_use == '0)
        begin
            last_frame = '0;
        end
        else if (frames_in_use >= NFR_W'(MAX_FRAMES))
        begin
            last_frame = FRAME_W'(MAX_FRAMES - 1);
        end
        else
        begin
            last_frame = FRAME_W'(frames_in_use - 1'b1);
        end

        if (pages_in_use == '0)
        begin
            npages = NPG_W'(1);
        end
        else if (pages_in_use > NPG_W'(MAX_PAGES))
        begin
            npages = NPG_W'(MAX_PAGES);
        end
        else
        begin
            npages = pages_in_use;
        end
    end

    assign scan_owner  = owner_reg[scan_reg];
    assign scan_age    = age_reg[scan_owner];
    assign scan_better = !have_best_reg || (scan_age < best_age_reg);

    assign stat.bad       = {1'b0, page_reg} >= npages;
    assign stat.hit       = loc_valid_reg[page_reg];
    assign stat.scan_done = !occupied_reg[scan_reg] || (scan_reg == last_frame);
    assign stat.out_free  = !res_valid_reg || !res_stall;

    assign miss  = !stat.bad && !stat.hit;
    assign evict = miss && !found_empty_reg;

    assign count_next = (miss && (count_reg != '1)) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        res_next               = '0;
        res_next.fault_total   = count_next;
        res_next.bad_page      = stat.bad;
        if (!stat.bad)
        begin
            res_next.fault       = miss;
            res_next.frame_index = stat.hit ? loc_rdata_reg : victim_reg;
            if (evict)
            begin
                res_next.evicted_valid = 1'b1;
                res_next.evicted_page  = best_owner_reg;
            end
        end
    end

    // Item latch and registered read of the page location.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg      <= ref_data.page;
            last_reg      <= ref_data.last_ref;
            loc_rdata_reg <= loc_mem[ref_data.page];
        end
        if (cmd.commit && miss)
        begin
            loc_mem[page_reg]   <= victim_reg;
            owner_reg[victim_reg] <= page_reg;
        end
    end

    // Victim search registers; the earliest frame wins on equal ages.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_reg        <= '0;
            have_best_reg   <= 1'b0;
            found_empty_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (!occupied_reg[scan_reg])
            begin
                found_empty_reg <= 1'b1;
                victim_reg      <= scan_reg;
            end
            else if (scan_better)
            begin
                have_best_reg  <= 1'b1;
                best_age_reg   <= scan_age;
                best_owner_reg <= scan_owner;
                victim_reg     <= scan_reg;
            end
        end
    end

    // Mapping state, ages and the fault count; a last reference clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg  <= '0;
            loc_valid_reg <= '0;
            count_reg     <= '0;
            for (int k = 0; k < MAX_PAGES; k++)
            begin
                age_reg[k] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (last_reg)
            begin
                occupied_reg  <= '0;
                loc_valid_reg <= '0;
                count_reg     <= '0;
                for (int k = 0; k < MAX_PAGES; k++)
                begin
                    age_reg[k] <= '0;
                end
            end
            else
            begin
                count_reg <= count_next;
                if (miss)
                begin
                    occupied_reg[victim_reg] <= 1'b1;
                    if (evict)
                    begin
                        loc_valid_reg[best_owner_reg] <= 1'b0;
                    end
                    loc_valid_reg[page_reg] <= 1'b1;
                end
                if (!stat.bad)
                begin
                    for (int k = 0; k < MAX_PAGES; k++)
                    begin
                        age_reg[k] <= {(PAGE_W'(k) == page_reg), age_reg[k][AGE_BITS-1:1]};
                    end
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // A result is only written into a free output register.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!res_valid_reg || !res_stall))
        else $error("result written over a pending beat");

    // An eviction only happens on a fault, and never on a rejected page.
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.evicted_valid) |-> (res_reg.fault && !res_reg.bad_page))
        else $error("eviction without a fault");

    // The fault count only drops when a last reference clears the state.
    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < $past(count_reg)) |-> ($past(cmd.commit) && $past(last_reg)))
        else $error("fault count dropped without a clear");

    // An evicting search always ends on an occupied frame.
    a_evict_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && evict && !last_reg) |-> occupied_reg[victim_reg])
        else $error("eviction from an empty frame");

endmodule

FILE: rtl/aging_page_replacement_core.sv
// Aging page replacement core (an LRU approximation over page frames).
// Reference beats enter on ref_valid/ref_data (page, last_ref) and are taken
// at an edge where ref_valid is high and ref_stall is low. Each reference
// produces exactly one result beat on res_valid/res_data: fault flag, frame
// used, evicted page, running fault count and a bad-page flag.
// A hit or a rejected page goes from the lookup straight to the result.
// A miss adds a victim search that visits one frame per cycle, stopping at
// the first empty frame or at the last frame in use. The frame scan sets
// the rate; one reference is in work at a time, and the core takes the next
// one in the cycle after its result is written. If the receiver stalls, the
// result beat holds in the output register; the next reference is still
// accepted and searched, and waits to be written until the pending beat is
// taken.
// Reset empties every frame, marks all pages non-resident, clears all ages
// and the fault count, and sets frames_in_use to 16 and pages_in_use to 64.
// A reference with last_ref set clears the frames, residency, ages and the
// fault count after its result. Configuration goes through the APB port
// (frames_in_use at 0x0, pages_in_use at 0x4); the user must write it only
// while the core is idle, and the core itself does not enforce this.
module aging_page_replacement_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ref_valid,
    output logic                ref_stall,
    input  apr_pkg::ref_t       ref_data,
    output logic                res_valid,
    input  logic                res_stall,
    output apr_pkg::res_t       res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import apr_pkg::*;

    logic [NFR_W-1:0] frames_reg;
    logic [NPG_W-1:0] pages_reg;
    logic             reg_sel;
    logic             cfg_write;

    cmd_t  cmd;
    stat_t stat;
    logic  idle;

    // The register index is the word address; byte lanes are ignored.
    assign reg_sel   = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
            pages_reg  <= PAGES_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_FRAMES_IN_USE)
            begin
                frames_reg <= pwdata[NFR_W-1:0];
            end
            else
            begin
                pages_reg <= pwdata[NPG_W-1:0];
            end
        end
    end

    // Reads return the stored register value, zero extended.
    always_comb
    begin
        if (reg_sel == REG_FRAMES_IN_USE)
        begin
            prdata = {{(32-NFR_W){1'b0}}, frames_reg};
        end
        else
        begin
            prdata = {{(32-NPG_W){1'b0}}, pages_reg};
        end
    end

    // The controller only takes a new reference while it is idle.
    assign ref_stall = !idle;

    apr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .ref_valid (ref_valid),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle)
    );

    apr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .ref_data      (ref_data),
        .frames_in_use (frames_reg),
        .pages_in_use  (pages_reg),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res_data      (res_data)
    );

endmodule
